FILE: sv/cis_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cis_pkg;

	// Characters that steer the field parser.
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;

	// Saturation limits of the digit accumulator and of a field value.
	localparam logic [16:0] ACC_CAP  = 17'd65536;
	localparam logic [16:0] POS_LIM  = 17'd32767;
	localparam logic [16:0] NEG_LIM  = 17'd32768;
	localparam logic signed [15:0] VAL_MAX = 16'sh7FFF;
	localparam logic signed [15:0] VAL_MIN = -16'sh8000;

	typedef enum logic [1:0] {
		PH_LEAD,
		PH_DIGITS,
		PH_SKIP
	} phase_t;

	typedef enum logic [3:0] {
		ST_RUN,
		ST_CLOSE,
		ST_FLUSH,
		ST_PREP,
		ST_PREP2,
		ST_MDIV,
		ST_VDIV,
		ST_SQRT,
		ST_OUT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic byte_en;
		logic close_open;
		logic prep;
		logic prep2;
		logic take_mean;
		logic start_sqrt;
		logic clear;
	} cis_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic div_done;
		logic sqrt_done;
	} cis_sts_t;

endpackage

`default_nettype wire

FILE: sv/csv_integer_stream_statistics_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Statistics over one text message of comma-separated integers.
// Input channel: one character per beat (message_byte) with last_byte marking
// the final character, under in_valid / in_stall. While a message streams in,
// a beat is taken every cycle. Fields are parsed as atoi does and clamped to
// 16-bit signed values.
// Output channel: one result beat per message under out_valid / out_stall,
// carrying count, minimum, maximum, mean and population standard deviation
// (both Q.8), and an overflow flag, from an output register.
// After the last byte the block stalls its input while it finishes, using the
// bit-serial divider (used twice) and the square root unit. The result beat
// is offered in the same cycle as that stall ends.
// The result is held until taken. A stalled result does not block the next
// message; only if that message finishes while the result still waits does
// the input stay stalled until the old result is taken.
// Reset clears the parser and statistics and leaves the block ready for
// input.

module csv_integer_stream_statistics_top #(
	parameter int MAX_FIELDS = 256
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [7:0]         message_byte,
	input  wire logic               last_byte,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic      [8:0]         field_total,
	output logic signed [15:0]      min_value,
	output logic signed [15:0]      max_value,
	output logic signed [23:0]      mean_q8,
	output logic      [22:0]        deviation_q8,
	output logic                    overflow_seen
);

	cis_pkg::cis_cmd_t cmd;
	cis_pkg::cis_sts_t sts;

	cis_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.last_byte (last_byte),
		.out_stall (out_stall),
		.sts       (sts),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	cis_dp #(
		.MAX_FIELDS (MAX_FIELDS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.message_byte  (message_byte),
		.field_total   (field_total),
		.min_value     (min_value),
		.max_value     (max_value),
		.mean_q8       (mean_q8),
		.deviation_q8  (deviation_q8),
		.overflow_seen (overflow_seen)
	);

endmodule

`default_nettype wire

FILE: sv/cis_div.sv
`timescale 1ns / 1ps
`default_nettype none

module cis_div #(
	parameter int DVW = 64,
	parameter int NVW = 18
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire logic [DVW-1:0] dividend,
	input  wire logic [NVW-1:0] divisor,
	output logic      [DVW-1:0] quot,
	output logic                done
);

	localparam int CNW = $clog2(DVW + 1);

	logic [DVW-1:0] qr_q;
	logic [NVW:0]   rem_q;
	logic [NVW-1:0] div_q;
	logic [CNW-1:0] cnt_q;
	logic           busy_q;
	logic           done_q;
	logic [NVW:0]   trial;
	logic           ge;
	logic [NVW:0]   rem_n;

	// One restoring step: shift in the next dividend bit, subtract if it fits.
	always_comb begin
		trial = {rem_q[NVW-1:0], qr_q[DVW-1]};
		ge    = trial >= {1'b0, div_q};
		rem_n = ge ? trial - {1'b0, div_q} : trial;
	end

	// Step counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNW'(DVW - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Quotient and remainder registers.
	always_ff @(posedge clk) begin
		if (start) begin
			qr_q  <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			qr_q  <= {qr_q[DVW-2:0], ge};
			rem_q <= rem_n;
		end
	end

	assign quot = qr_q;
	assign done = done_q;

endmodule

`default_nettype wire

FILE: sv/cis_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module cis_dp #(
	parameter int MAX_FIELDS = 256
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cis_pkg::cis_cmd_t  cmd,
	output cis_pkg::cis_sts_t       sts,
	input  wire logic [7:0]         message_byte,
	output logic      [8:0]         field_total,
	output logic signed [15:0]      min_value,
	output logic signed [15:0]      max_value,
	output logic signed [23:0]      mean_q8,
	output logic      [22:0]        deviation_q8,
	output logic                    overflow_seen
);

	localparam int CW  = $clog2(MAX_FIELDS + 1);
	localparam int SW  = 16 + CW;
	localparam int QW  = 30 + CW;
	localparam int PW  = CW + QW;
	localparam int XW  = 2 * SW;
	localparam int NVW = 2 * CW;
	localparam int DVW = PW + 16;
	localparam int RW  = DVW / 2;
	localparam int RCW = $clog2(RW + 1);

	// Field parser state.
	cis_pkg::phase_t ph_q, ph_n;
	logic [16:0]     acc_q, acc_n;
	logic            neg_q, neg_n;
	logic            push;
	logic            is_digit, is_ws, is_sign;
	logic [20:0]     acc_mul;
	logic [16:0]     acc_cap;
	logic signed [15:0] v_new;
	logic            sat_new;

	// Value stage between parser and statistics.
	logic               vld_s1;
	logic signed [15:0] v_s1;
	logic               sat_s1;

	// Statistics.
	logic [CW-1:0]      count_q;
	logic signed [SW-1:0] sum_q;
	logic [QW-1:0]      sumsq_q;
	logic signed [15:0] min_q, max_q;
	logic               flag_q;
	logic signed [31:0] vsq;

	// Final arithmetic.
	logic [SW-1:0]  mag_q;
	logic [PW-1:0]  prod_q;
	logic [NVW-1:0] n2_q;
	logic [XW-1:0]  sqv_q;
	logic [23:0]    mean_q;
	logic [XW-1:0]  prod_ext;
	logic [PW-1:0]  dvar;
	logic           div_start;
	logic [DVW-1:0] div_dividend;
	logic [NVW-1:0] div_divisor;
	logic [DVW-1:0] quot;
	logic           div_done;

	// Square root unit.
	logic [DVW-1:0] sx_q;
	logic [RW-1:0]  root_q;
	logic [RW+1:0]  srem_q;
	logic [RCW-1:0] scnt_q;
	logic           sbusy_q;
	logic           sdone_q;
	logic [RW+1:0]  s_trial;
	logic [RW+1:0]  s_sub;
	logic           s_ge;

	// Result register.
	logic [8:0]         total_q;
	logic signed [15:0] omin_q, omax_q;
	logic [23:0]        omean_q;
	logic [22:0]        odev_q;
	logic               oovf_q;

	// Character classes.
	always_comb begin
		is_digit = (message_byte >= cis_pkg::CH_ZERO) && (message_byte <= cis_pkg::CH_NINE);
		is_ws    = (message_byte == cis_pkg::CH_SPACE) ||
			((message_byte >= cis_pkg::CH_TAB) && (message_byte <= cis_pkg::CH_CR));
		is_sign  = (message_byte == cis_pkg::CH_PLUS) || (message_byte == cis_pkg::CH_MINUS);
		acc_mul  = 21'(acc_q) * 21'd10 + 21'(message_byte[3:0]);
		acc_cap  = (acc_mul > 21'(cis_pkg::ACC_CAP)) ? cis_pkg::ACC_CAP : acc_mul[16:0];
	end

	// Clamp the open field to a 16-bit value.
	always_comb begin
		sat_new = 1'b0;
		if (neg_q) begin
			if (acc_q > cis_pkg::NEG_LIM) begin
				v_new   = cis_pkg::VAL_MIN;
				sat_new = 1'b1;
			end else begin
				v_new = 16'(17'd0 - acc_q);
			end
		end else begin
			if (acc_q > cis_pkg::POS_LIM) begin
				v_new   = cis_pkg::VAL_MAX;
				sat_new = 1'b1;
			end else begin
				v_new = 16'(acc_q);
			end
		end
	end

	// Parser next state; a comma or a close command hands the field on.
	always_comb begin
		ph_n  = ph_q;
		acc_n = acc_q;
		neg_n = neg_q;
		push  = 1'b0;
		if (cmd.byte_en) begin
			if (message_byte == cis_pkg::CH_COMMA) begin
				push = 1'b1;
			end else begin
				case (ph_q)
					cis_pkg::PH_LEAD: begin
						if (is_ws) begin
							ph_n = cis_pkg::PH_LEAD;
						end else if (is_sign) begin
							neg_n = (message_byte == cis_pkg::CH_MINUS);
							ph_n  = cis_pkg::PH_DIGITS;
						end else if (is_digit) begin
							acc_n = acc_cap;
							ph_n  = cis_pkg::PH_DIGITS;
						end else begin
							ph_n = cis_pkg::PH_SKIP;
						end
					end
					cis_pkg::PH_DIGITS: begin
						if (is_digit) begin
							acc_n = acc_cap;
						end else begin
							ph_n = cis_pkg::PH_SKIP;
						end
					end
					default: ph_n = ph_q;
				endcase
			end
		end
		if (cmd.close_open) begin
			push = 1'b1;
		end
		if (push) begin
			ph_n  = cis_pkg::PH_LEAD;
			acc_n = '0;
			neg_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= cis_pkg::PH_LEAD;
			acc_q  <= '0;
			neg_q  <= 1'b0;
			vld_s1 <= 1'b0;
		end else begin
			ph_q   <= ph_n;
			acc_q  <= acc_n;
			neg_q  <= neg_n;
			vld_s1 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			v_s1   <= v_new;
			sat_s1 <= sat_new;
		end
	end

	// Statistics update from the value stage.
	assign vsq = v_s1 * v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
			sumsq_q <= '0;
			min_q   <= cis_pkg::VAL_MAX;
			max_q   <= cis_pkg::VAL_MIN;
			flag_q  <= 1'b0;
		end else if (cmd.clear) begin
			count_q <= '0;
			sum_q   <= '0;
			sumsq_q <= '0;
			min_q   <= cis_pkg::VAL_MAX;
			max_q   <= cis_pkg::VAL_MIN;
			flag_q  <= 1'b0;
		end else if (vld_s1) begin
			if (count_q >= CW'(MAX_FIELDS)) begin
				flag_q <= 1'b1;
			end else begin
				count_q <= count_q + 1'b1;
				sum_q   <= sum_q + {{(SW-16){v_s1[15]}}, v_s1};
				sumsq_q <= sumsq_q + {{(QW-32){1'b0}}, vsq};
				if (v_s1 < min_q) begin
					min_q <= v_s1;
				end
				if (v_s1 > max_q) begin
					max_q <= v_s1;
				end
				if (sat_s1) begin
					flag_q <= 1'b1;
				end
			end
			if (sat_s1) begin
				flag_q <= 1'b1;
			end
		end
	end

	// Operands for mean and variance.
	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			mag_q  <= sum_q[SW-1] ? SW'(-sum_q) : SW'(sum_q);
			prod_q <= PW'(count_q) * PW'(sumsq_q);
			n2_q   <= NVW'(count_q) * NVW'(count_q);
		end
		if (cmd.prep2) begin
			sqv_q <= XW'(mag_q) * XW'(mag_q);
		end
		if (cmd.take_mean) begin
			mean_q <= sum_q[SW-1] ? 24'(24'd0 - quot[23:0]) : quot[23:0];
		end
	end

	// Divider operand selection: rounded mean first, then scaled variance.
	always_comb begin
		prod_ext  = XW'(prod_q);
		dvar      = (prod_ext >= sqv_q) ? PW'(prod_ext - sqv_q) : '0;
		div_start = cmd.prep2 | cmd.take_mean;
		if (cmd.take_mean) begin
			div_dividend = {dvar, 16'd0};
			div_divisor  = n2_q;
		end else begin
			div_dividend = DVW'({mag_q, 8'd0}) + DVW'(count_q >> 1);
			div_divisor  = NVW'(count_q);
		end
	end

	cis_div #(
		.DVW (DVW),
		.NVW (NVW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quot     (quot),
		.done     (div_done)
	);

	// Digit-by-digit square root, two radicand bits per cycle.
	always_comb begin
		s_trial = {srem_q[RW-1:0], sx_q[DVW-1:DVW-2]};
		s_sub   = {root_q, 2'b01};
		s_ge    = s_trial >= s_sub;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sbusy_q <= 1'b0;
			sdone_q <= 1'b0;
			scnt_q  <= '0;
		end else if (cmd.start_sqrt) begin
			sbusy_q <= 1'b1;
			sdone_q <= 1'b0;
			scnt_q  <= '0;
		end else if (sbusy_q) begin
			scnt_q <= scnt_q + 1'b1;
			if (scnt_q == RCW'(RW - 1)) begin
				sbusy_q <= 1'b0;
				sdone_q <= 1'b1;
			end
		end else begin
			sdone_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_sqrt) begin
			sx_q   <= quot;
			root_q <= '0;
			srem_q <= '0;
		end else if (sbusy_q) begin
			sx_q   <= {sx_q[DVW-3:0], 2'b00};
			srem_q <= s_ge ? s_trial - s_sub : s_trial;
			root_q <= {root_q[RW-2:0], s_ge};
		end
	end

	// The finished result moves to the output register as the statistics clear.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			omin_q  <= '0;
			omax_q  <= '0;
			omean_q <= '0;
			odev_q  <= '0;
			oovf_q  <= 1'b0;
		end else if (cmd.clear) begin
			total_q <= 9'(count_q);
			omin_q  <= min_q;
			omax_q  <= max_q;
			omean_q <= mean_q;
			odev_q  <= root_q[22:0];
			oovf_q  <= flag_q;
		end
	end

	assign sts.div_done  = div_done;
	assign sts.sqrt_done = sdone_q;

	assign field_total   = total_q;
	assign min_value     = omin_q;
	assign max_value     = omax_q;
	assign mean_q8       = omean_q;
	assign deviation_q8  = odev_q;
	assign overflow_seen = oovf_q;

	// The field count never passes its limit.
	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_FIELDS))
		else $error("field count above limit");

	// Once a field is counted, the minimum does not exceed the maximum.
	a_min_max: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0) |-> (min_q <= max_q))
		else $error("minimum above maximum");

	// With no field counted, the sums are empty.
	a_empty_sums: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> ((sum_q == '0) && (sumsq_q == '0)))
		else $error("sums not empty without fields");

endmodule

`default_nettype wire

FILE: sv/cis_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module cis_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              last_byte,
	input  wire logic              out_stall,
	input  wire cis_pkg::cis_sts_t sts,
	output logic                   in_stall,
	output logic                   out_valid,
	output cis_pkg::cis_cmd_t      cmd
);

	cis_pkg::state_t state_q, state_n;
	logic            out_valid_q;
	logic            out_free;

	// The result register can take a new result when it is empty or being taken.
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cis_pkg::ST_RUN;
		end else begin
			state_q <= state_n;
		end
	end

	// Result valid flag: set when a result is loaded, cleared when it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.clear) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	// Next state.
	always_comb begin
		state_n = state_q;
		case (state_q)
			cis_pkg::ST_RUN: begin
				if (in_valid && last_byte) begin
					state_n = cis_pkg::ST_CLOSE;
				end
			end
			cis_pkg::ST_CLOSE: state_n = cis_pkg::ST_FLUSH;
			cis_pkg::ST_FLUSH: state_n = cis_pkg::ST_PREP;
			cis_pkg::ST_PREP:  state_n = cis_pkg::ST_PREP2;
			cis_pkg::ST_PREP2: state_n = cis_pkg::ST_MDIV;
			cis_pkg::ST_MDIV: begin
				if (sts.div_done) begin
					state_n = cis_pkg::ST_VDIV;
				end
			end
			cis_pkg::ST_VDIV: begin
				if (sts.div_done) begin
					state_n = cis_pkg::ST_SQRT;
				end
			end
			cis_pkg::ST_SQRT: begin
				if (sts.sqrt_done) begin
					state_n = cis_pkg::ST_OUT;
				end
			end
			cis_pkg::ST_OUT: begin
				if (out_free) begin
					state_n = cis_pkg::ST_RUN;
				end
			end
			default: state_n = cis_pkg::ST_RUN;
		endcase
	end

	// Outputs and datapath commands.
	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			cis_pkg::ST_RUN: begin
				in_stall    = 1'b0;
				cmd.byte_en = in_valid;
			end
			cis_pkg::ST_CLOSE: cmd.close_open = 1'b1;
			cis_pkg::ST_PREP:  cmd.prep = 1'b1;
			cis_pkg::ST_PREP2: cmd.prep2 = 1'b1;
			cis_pkg::ST_MDIV:  cmd.take_mean = sts.div_done;
			cis_pkg::ST_VDIV:  cmd.start_sqrt = sts.div_done;
			cis_pkg::ST_OUT:   cmd.clear = out_free;
			default: cmd = '0;
		endcase
	end

endmodule

`default_nettype wire
